// File: design/rfps_pkg.sv
// ----------------------------------------------------------------------------
// rfps_pkg
// Shared types, command codes and DAC helpers for the rotated frame scaler.
// ----------------------------------------------------------------------------
package rfps_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_PAL   = 2'd2,
    CMD_FETCH = 2'd3
  } cmd_t;

  // Register indexes on the config port.
  localparam logic [3:0] ADDR_WIDTH  = 4'h0;
  localparam logic [3:0] ADDR_HEIGHT = 4'h4;
  localparam logic [3:0] ADDR_STRIDE = 4'h8;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_DIV,
    BK_READ_FRAME,
    BK_READ_PAL,
    BK_OUT
  } back_state_t;

  // Queue word from front to back.
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  pen;
    logic [7:0]  pal_index;
    logic [7:0]  pal_colour;
    logic        plot_ok;
    logic [7:0]  plot_row;
    logic [7:0]  plot_col;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
  } work_t;

  // Weighted resistor DAC level of one PROM nibble.
  function automatic logic [8:0] dac_level(input logic [3:0] nib);
    logic [8:0] acc;
    acc = 9'd0;
    if (nib[0]) acc = acc + 9'h0e;
    if (nib[1]) acc = acc + 9'h1f;
    if (nib[2]) acc = acc + 9'h43;
    if (nib[3]) acc = acc + 9'h8f;
    return acc;
  endfunction

  function automatic logic [7:0] rgb332(input logic [3:0] r, input logic [3:0] g,
                                        input logic [3:0] b);
    logic [8:0] lr;
    logic [8:0] lg;
    logic [8:0] lb;
    lr = dac_level(r);
    lg = dac_level(g);
    lb = dac_level(b);
    return {lr[7:5], lg[7:5], lb[7:6]};
  endfunction

endpackage

// File: design/rotated_framebuffer_palette_scaler.sv
// ----------------------------------------------------------------------------
// rotated_framebuffer_palette_scaler
// Rotated frame store with palette and nearest-neighbour fetch scaling.
// ----------------------------------------------------------------------------
// Plot and palette writes take effect when the back end pops them; a fetch
// gives its word after two 21-step serial divides, then frame and palette
// memory reads. Clear holds the back end while it writes every frame-store
// word, one frame-store word per cycle.
// Reset: synchronous; clears registers to 224/256/224 and runs a clearing
// pass that zeroes the frame store. A two-word queue lets the front accept
// while the back end works.
module rotated_framebuffer_palette_scaler #(
  parameter int SRC_WIDTH    = 224,
  parameter int SRC_HEIGHT   = 256,
  parameter int ROT_Y_OFFSET = 16
) (
  input  logic              clk,
  input  logic              rst,
  // Input channel
  input  logic              valid,
  output logic              stall,
  input  logic [1:0]        cmd,
  input  logic signed [9:0] abs_x,
  input  logic signed [9:0] abs_y,
  input  logic [7:0]        pen,
  input  logic [7:0]        pal_index,
  input  logic [3:0]        prom_red,
  input  logic [3:0]        prom_green,
  input  logic [3:0]        prom_blue,
  input  logic [11:0]       dest_x,
  input  logic [11:0]       dest_y,
  // Output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        colour,
  output logic [27:0]       dest_address,
  // Config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [12:0]     dest_width;
  logic [12:0]     dest_height;
  logic [15:0]     dest_stride;
  logic            q_valid;
  logic            q_pop;
  rfps_pkg::work_t q_word;

  assign pready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width  <= 13'd224;
      dest_height <= 13'd256;
      dest_stride <= 16'd224;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        rfps_pkg::ADDR_WIDTH:  dest_width  <= pwdata[12:0];
        rfps_pkg::ADDR_HEIGHT: dest_height <= pwdata[12:0];
        rfps_pkg::ADDR_STRIDE: dest_stride <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      rfps_pkg::ADDR_WIDTH:  prdata = {19'd0, dest_width};
      rfps_pkg::ADDR_HEIGHT: prdata = {19'd0, dest_height};
      rfps_pkg::ADDR_STRIDE: prdata = {16'd0, dest_stride};
      default:               prdata = 32'd0;
    endcase
  end

  rfps_front #(
    .SRC_WIDTH    (SRC_WIDTH),
    .SRC_HEIGHT   (SRC_HEIGHT),
    .ROT_Y_OFFSET (ROT_Y_OFFSET)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .valid      (valid),
    .stall      (stall),
    .cmd        (cmd),
    .abs_x      (abs_x),
    .abs_y      (abs_y),
    .pen        (pen),
    .pal_index  (pal_index),
    .prom_red   (prom_red),
    .prom_green (prom_green),
    .prom_blue  (prom_blue),
    .dest_x     (dest_x),
    .dest_y     (dest_y),
    .q_valid    (q_valid),
    .q_word     (q_word),
    .q_pop      (q_pop)
  );

  rfps_back #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .q_pop        (q_pop),
    .dest_width   (dest_width),
    .dest_height  (dest_height),
    .dest_stride  (dest_stride),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .colour       (colour),
    .dest_address (dest_address)
  );

endmodule

// File: design/rfps_front.sv
// ----------------------------------------------------------------------------
// rfps_front
// Accepts input words, does rotation and palette conversion, queues work.
// ----------------------------------------------------------------------------
module rfps_front #(
  parameter int SRC_WIDTH    = 224,
  parameter int SRC_HEIGHT   = 256,
  parameter int ROT_Y_OFFSET = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 stall,
  input  logic [1:0]           cmd,
  input  logic signed [9:0]    abs_x,
  input  logic signed [9:0]    abs_y,
  input  logic [7:0]           pen,
  input  logic [7:0]           pal_index,
  input  logic [3:0]           prom_red,
  input  logic [3:0]           prom_green,
  input  logic [3:0]           prom_blue,
  input  logic [11:0]          dest_x,
  input  logic [11:0]          dest_y,
  output logic                 q_valid,
  output rfps_pkg::work_t      q_word,
  input  logic                 q_pop
);

  localparam int QDEPTH = 2;

  rfps_pkg::work_t  fifo [QDEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  rfps_pkg::work_t  w;
  logic signed [11:0] col;
  logic signed [11:0] row;

  assign stall = (count == 2'(QDEPTH));
  assign push  = valid && !stall;

  always_comb begin
    col = 12'(abs_y) - 12'(ROT_Y_OFFSET);
    row = 12'sd255 - 12'(abs_x);
    w.cmd        = rfps_pkg::cmd_t'(cmd);
    w.pen        = pen;
    w.pal_index  = pal_index;
    w.pal_colour = rfps_pkg::rgb332(prom_red, prom_green, prom_blue);
    w.plot_ok    = (col >= 0) && (col < 12'(SRC_WIDTH)) &&
                   (row >= 0) && (row < 12'(SRC_HEIGHT));
    w.plot_row   = row[7:0];
    w.plot_col   = col[7:0];
    w.dest_x     = dest_x;
    w.dest_y     = dest_y;
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  assign q_valid = (count != 2'd0);
  assign q_word  = fifo[rd_ptr];

endmodule

// File: design/rfps_div.sv
// ----------------------------------------------------------------------------
// rfps_div
// Restoring divider, one quotient bit per cycle, 21-bit dividend.
// ----------------------------------------------------------------------------
module rfps_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [20:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [20:0] quotient
);

  logic [4:0]  cnt;
  logic        busy;
  logic [13:0] rem;
  logic [20:0] quo;
  logic [12:0] dsr;
  logic [13:0] trial;
  logic [14:0] diff;

  assign trial = {rem[12:0], quo[20]};
  assign diff  = {1'b0, trial} - {2'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd20;
      end else if (busy) begin
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 14'd0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[14]) begin
        rem <= diff[13:0];
        quo <= {quo[19:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[19:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

// File: design/rfps_back.sv
// ----------------------------------------------------------------------------
// rfps_back
// Executes queued work: frame store, palette, scaling and output register.
// ----------------------------------------------------------------------------
module rfps_back #(
  parameter int SRC_WIDTH  = 224,
  parameter int SRC_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  rfps_pkg::work_t   q_word,
  output logic              q_pop,
  input  logic [12:0]       dest_width,
  input  logic [12:0]       dest_height,
  input  logic [15:0]       dest_stride,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        colour,
  output logic [27:0]       dest_address
);

  localparam int FRAME_PENS = SRC_WIDTH * SRC_HEIGHT;
  localparam int AW         = $clog2(FRAME_PENS + 1);

  rfps_pkg::back_state_t state, state_next;

  logic [7:0]    frame_mem [FRAME_PENS];
  logic [7:0]    pal_mem   [256];
  logic [AW-1:0] clr_addr;
  logic [7:0]    clr_pen;
  logic [7:0]    frame_q;
  logic [7:0]    pal_q;
  rfps_pkg::work_t cur;
  logic          div_sel;
  logic          div_start;
  logic          div_done;
  logic [20:0]   dividend;
  logic [12:0]   divisor;
  logic [20:0]   quotient;
  logic [20:0]   sx;
  logic [AW+8:0] idx_full;
  logic [AW-1:0] idx;
  logic [27:0]   addr_calc;
  logic          fe_ok;

  assign fe_ok = ({1'b0, q_word.dest_x} < dest_width) &&
                 ({1'b0, q_word.dest_y} < dest_height);

  always_comb begin
    q_pop = 1'b0;
    if (state == rfps_pkg::BK_IDLE && q_valid) q_pop = 1'b1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rfps_pkg::BK_IDLE: begin
        if (q_valid) begin
          unique case (q_word.cmd)
            rfps_pkg::CMD_CLEAR: state_next = rfps_pkg::BK_CLEAR;
            rfps_pkg::CMD_FETCH: state_next = fe_ok ? rfps_pkg::BK_DIV : rfps_pkg::BK_IDLE;
            default:             state_next = rfps_pkg::BK_IDLE;
          endcase
        end
      end
      rfps_pkg::BK_CLEAR:
        if (clr_addr == AW'(FRAME_PENS - 1)) state_next = rfps_pkg::BK_IDLE;
      rfps_pkg::BK_DIV:
        if (div_done && div_sel) state_next = rfps_pkg::BK_READ_FRAME;
      rfps_pkg::BK_READ_FRAME: state_next = rfps_pkg::BK_READ_PAL;
      rfps_pkg::BK_READ_PAL:   state_next = rfps_pkg::BK_OUT;
      rfps_pkg::BK_OUT:        if (!out_valid) state_next = rfps_pkg::BK_IDLE;
      default:                 state_next = rfps_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rfps_pkg::BK_CLEAR;
      clr_addr  <= '0;
      clr_pen   <= 8'd0;
      div_sel   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        clr_addr <= '0;
        clr_pen  <= q_word.pen;
        div_sel  <= 1'b0;
      end else if (state == rfps_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == rfps_pkg::BK_DIV && div_done) div_sel <= 1'b1;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      else if (state == rfps_pkg::BK_READ_PAL) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_word;
  end

  // Divider: first column, then row.
  assign div_start = (q_pop && q_word.cmd == rfps_pkg::CMD_FETCH && fe_ok) ||
                     (state == rfps_pkg::BK_DIV && div_done && !div_sel);
  always_comb begin
    if (q_pop) begin
      dividend = 21'(q_word.dest_x) * 21'(SRC_WIDTH);
      divisor  = dest_width;
    end else begin
      dividend = 21'(cur.dest_y) * 21'(SRC_HEIGHT);
      divisor  = dest_height;
    end
  end

  rfps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (state == rfps_pkg::BK_DIV && div_done && !div_sel) sx <= quotient;
  end

  always_ff @(posedge clk) begin
    if (state == rfps_pkg::BK_DIV && div_done && div_sel) begin
      if (idx_full >= (AW+9)'(FRAME_PENS)) idx <= AW'(FRAME_PENS - 1);
      else idx <= idx_full[AW-1:0];
      addr_calc <= 28'(cur.dest_y) * 28'(dest_stride) + 28'(cur.dest_x);
    end
  end
  assign idx_full = (AW+9)'(quotient[8:0]) * (AW+9)'(SRC_WIDTH) + (AW+9)'(sx[8:0]);

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state == rfps_pkg::BK_CLEAR)
      frame_mem[clr_addr] <= clr_pen;
    else if (q_pop && q_word.cmd == rfps_pkg::CMD_PLOT && q_word.plot_ok)
      frame_mem[AW'(q_word.plot_row) * AW'(SRC_WIDTH) + AW'(q_word.plot_col)] <= q_word.pen;
    if (state == rfps_pkg::BK_READ_FRAME) frame_q <= frame_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_word.cmd == rfps_pkg::CMD_PAL)
      pal_mem[q_word.pal_index] <= q_word.pal_colour;
    if (state == rfps_pkg::BK_READ_PAL) pal_q <= pal_mem[frame_q];
  end

  always_ff @(posedge clk) begin
    if (state == rfps_pkg::BK_READ_PAL) dest_address <= addr_calc;
  end
  assign colour = pal_q;

endmodule

// File: sim/tb_rotated_framebuffer_palette_scaler.sv
// ----------------------------------------------------------------------------
// tb_rotated_framebuffer_palette_scaler
// Self-checking bench for the rotated frame scaler. It sends clear, plot,
// palette and fetch words, keeps its own copy of the frame store, the palette
// and the size registers, and checks every returned colour and address in
// order. Destination sizes are changed over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_rotated_framebuffer_palette_scaler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SRC_W     = 224;
  localparam int SRC_H     = 256;
  localparam int Y_OFS     = 16;
  localparam int NPENS     = SRC_W * SRC_H;
  // pending cycles with no handshake; covers a full clearing pass
  localparam int STUCK_MAX = 200000;

  typedef struct {
    rfps_pkg::cmd_t    cmd;
    logic signed [9:0] ax;
    logic signed [9:0] ay;
    logic [7:0]        pen;
    logic [7:0]        idx;
    logic [3:0]        r;
    logic [3:0]        g;
    logic [3:0]        b;
    logic [11:0]       dx;
    logic [11:0]       dy;
  } word_t;

  typedef struct {
    logic [7:0]  colour;
    logic [27:0] addr;
  } pixel_t;

  logic clk, rst;
  logic valid = 1'b0;
  logic stall;
  logic [1:0] cmd;
  logic signed [9:0] abs_x, abs_y;
  logic [7:0] pen, pal_index;
  logic [3:0] prom_red, prom_green, prom_blue;
  logic [11:0] dest_x, dest_y;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] colour;
  logic [27:0] dest_address;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  rotated_framebuffer_palette_scaler DUT (.*);

  // bench copy of block state
  logic [7:0]  frame_pens [NPENS];
  logic [7:0]  palette [256];
  bit          pal_set [256];
  int unsigned width_reg, height_reg, stride_reg;

  word_t  words_to_send [$];
  pixel_t pixels_due [$];
  int     idle_pct, stall_pct;
  int     mismatches = 0;
  logic   in_fire = 1'b0;
  int     stuck_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one word to the bench state, queues any pixel it yields
  // ---------------------------------------------------------------------------
  function automatic logic [8:0] resistor_level(logic [3:0] nib);
    return (nib[0] ? 9'h0e : 9'h0) + (nib[1] ? 9'h1f : 9'h0) +
           (nib[2] ? 9'h43 : 9'h0) + (nib[3] ? 9'h8f : 9'h0);
  endfunction

  // Pen index a fetch would read, or -1 when the fetch is off the destination.
  function automatic int fetch_pen(logic [11:0] dx, logic [11:0] dy);
    int unsigned sx, sy, a;
    if (dx >= width_reg || dy >= height_reg) return -1;
    sx = (dx * SRC_W) / width_reg;
    sy = (dy * SRC_H) / height_reg;
    a  = sy * SRC_W + sx;
    if (a >= NPENS) a = NPENS - 1;
    return frame_pens[a];
  endfunction

  function automatic void apply_word(word_t w);
    int col, row, p;
    logic [8:0] lr, lg, lb;
    logic [63:0] full_addr;
    pixel_t px;
    case (w.cmd)
      rfps_pkg::CMD_CLEAR: foreach (frame_pens[i]) frame_pens[i] = w.pen;
      rfps_pkg::CMD_PLOT: begin
        col = int'(w.ay) - Y_OFS;
        row = 255 - int'(w.ax);
        if (col >= 0 && col < SRC_W && row >= 0 && row < SRC_H)
          frame_pens[row * SRC_W + col] = w.pen;
      end
      rfps_pkg::CMD_PAL: begin
        lr = resistor_level(w.r);
        lg = resistor_level(w.g);
        lb = resistor_level(w.b);
        palette[w.idx] = {lr[7:5], lg[7:5], lb[7:6]};
        pal_set[w.idx] = 1'b1;
      end
      default: begin
        p = fetch_pen(w.dx, w.dy);
        if (p >= 0) begin
          full_addr = 64'(w.dy) * 64'(stride_reg) + 64'(w.dx);
          px.colour = palette[p];
          px.addr   = full_addr[27:0];
          pixels_due.push_back(px);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders: every word carries random filler in the unused fields
  // ---------------------------------------------------------------------------
  function automatic word_t noise_word(rfps_pkg::cmd_t c);
    word_t w;
    w.cmd = c;
    w.ax  = 10'($urandom);
    w.ay  = 10'($urandom);
    w.pen = 8'($urandom);
    w.idx = 8'($urandom);
    w.r   = 4'($urandom);
    w.g   = 4'($urandom);
    w.b   = 4'($urandom);
    w.dx  = 12'($urandom);
    w.dy  = 12'($urandom);
    return w;
  endfunction

  function automatic void send(word_t w);
    apply_word(w);
    words_to_send.push_back(w);
  endfunction

  function automatic void send_pal(logic [7:0] i, logic [3:0] r, logic [3:0] g,
                                   logic [3:0] b);
    word_t w;
    w = noise_word(rfps_pkg::CMD_PAL);
    w.idx = i; w.r = r; w.g = g; w.b = b;
    send(w);
  endfunction

  function automatic void send_plot(int x, int y, logic [7:0] p);
    word_t w;
    w = noise_word(rfps_pkg::CMD_PLOT);
    w.ax = 10'(x); w.ay = 10'(y); w.pen = p;
    send(w);
  endfunction

  // A fetch never reads a palette entry that was not written: fill it first.
  function automatic void send_fetch(logic [11:0] x, logic [11:0] y);
    word_t w;
    int p;
    p = fetch_pen(x, y);
    if (p >= 0 && !pal_set[p])
      send_pal(8'(p), 4'($urandom), 4'($urandom), 4'($urandom));
    w = noise_word(rfps_pkg::CMD_FETCH);
    w.dx = x; w.dy = y;
    send(w);
  endfunction

  function automatic void send_clear(logic [7:0] p);
    word_t w;
    w = noise_word(rfps_pkg::CMD_CLEAR);
    w.pen = p;
    send(w);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: new word on the falling edge once the last one was taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) in_fire <= valid && !stall;

  always @(negedge clk) begin
    if (!rst && (!valid || in_fire)) begin
      if (words_to_send.size() > 0 && $urandom_range(99) >= idle_pct) begin
        word_t w;
        w = words_to_send.pop_front();
        valid      <= 1'b1;
        cmd        <= w.cmd;
        abs_x      <= w.ax;
        abs_y      <= w.ay;
        pen        <= w.pen;
        pal_index  <= w.idx;
        prom_red   <= w.r;
        prom_green <= w.g;
        prom_blue  <= w.b;
        dest_x     <= w.dx;
        dest_y     <= w.dy;
      end else begin
        valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Output monitor and stuck watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: colour=%h addr=%h", colour, dest_address);
      end else begin
        pixel_t e;
        e = pixels_due.pop_front();
        if (colour !== e.colour || dest_address !== e.addr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: colour exp %h got %h, addr exp %h got %h",
                     e.colour, colour, e.addr, dest_address);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((valid && !stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else if (valid || words_to_send.size() > 0 || pixels_due.size() > 0)
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles > STUCK_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------
  task automatic drain(int tail);
    while (words_to_send.size() > 0 || valid || pixels_due.size() > 0)
      @(posedge clk);
    // clear and plot words give no output; let the back end go quiet
    repeat (tail) @(posedge clk);
  endtask

  task automatic reg_write(logic [3:0] a, logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_sizes(int unsigned w, int unsigned h, int unsigned s);
    reg_write(rfps_pkg::ADDR_WIDTH, w);
    reg_write(rfps_pkg::ADDR_HEIGHT, h);
    reg_write(rfps_pkg::ADDR_STRIDE, s);
    width_reg  = w & 32'h1fff;
    height_reg = h & 32'h1fff;
    stride_reg = s & 32'hffff;
  endtask

  // Random mix; mostly legal plots and in-range fetches.
  function automatic void random_word();
    int k, xmax, ymax;
    k = $urandom_range(99);
    xmax = (width_reg == 0) ? 0 : ((width_reg > 4096) ? 4095 : width_reg - 1);
    ymax = (height_reg == 0) ? 0 : ((height_reg > 4096) ? 4095 : height_reg - 1);
    if (k < 45) begin
      if ($urandom_range(9) == 0) send_fetch(12'($urandom), 12'($urandom));
      else send_fetch(12'($urandom_range(xmax)), 12'($urandom_range(ymax)));
    end else if (k < 75) begin
      if ($urandom_range(7) == 0)
        send_plot($urandom_range(1023) - 512, $urandom_range(1023) - 512, 8'($urandom));
      else
        send_plot($urandom_range(255), $urandom_range(239, 16), 8'($urandom));
    end else begin
      send_pal(8'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sizes [10][3];
    bit had_clear;
    sizes = '{'{224, 256, 224}, '{1, 1, 1}, '{4096, 4096, 65535}, '{112, 128, 300},
              '{8191, 8191, 65535}, '{448, 512, 448}, '{0, 256, 224},
              '{300, 37, 1000}, '{4096, 1, 7}, '{1, 4096, 65535}};
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    idle_pct = 0; stall_pct = 0;
    foreach (frame_pens[i]) frame_pens[i] = 8'h00;
    foreach (palette[i]) begin
      palette[i] = 8'h00;
      pal_set[i] = 1'b0;
    end
    width_reg = 224; height_reg = 256; stride_reg = 224;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: DAC corners, rotation edges, fetch corners and misses.
    set_sizes(224, 256, 224);
    send_pal(8'h00, 4'h0, 4'h0, 4'h0);
    send_pal(8'hff, 4'hf, 4'hf, 4'hf);
    send_pal(8'h01, 4'h1, 4'h2, 4'h4);
    send_pal(8'h02, 4'h8, 4'h4, 4'h8);
    send_plot(255, 16, 8'h01);   // row 0, col 0
    send_plot(0, 239, 8'hff);    // row 255, col 223
    send_plot(-256, 100, 8'h02); // row off the bottom
    send_plot(511, 100, 8'h02);  // negative row
    send_plot(100, 15, 8'h02);   // column left of frame
    send_plot(100, 240, 8'h02);  // column right of frame
    send_plot(256, -256, 8'h02);
    send_fetch(12'd0, 12'd0);
    send_fetch(12'd223, 12'd255);
    send_fetch(12'd224, 12'd0);  // just past width
    send_fetch(12'd0, 12'd256);  // just past height
    send_fetch(12'hfff, 12'hfff);
    send_clear(8'h02);
    send_fetch(12'd10, 12'd10);
    send_plot(128, 128, 8'h00);
    send_fetch(12'd112, 12'd127);
    drain(60000);

    // Random phases, each under its own sizes and idle pattern.
    for (int ph = 0; ph < 10; ph++) begin
      set_sizes(sizes[ph][0], sizes[ph][1], sizes[ph][2]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      had_clear = 1'b0;
      for (int n = 0; n < 53; n++) begin
        if (n == 26) begin
          // hold the sender until every pending pixel is back
          drain(0);
          if (ph == 3 || ph == 8) begin
            send_clear(8'($urandom));
            had_clear = 1'b1;
          end
        end
        random_word();
      end
      drain(had_clear ? 60000 : 100);
    end

    drain(100);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
design/rfps_pkg.sv
design/rfps_front.sv
design/rfps_div.sv
design/rfps_back.sv
design/rotated_framebuffer_palette_scaler.sv
sim/tb_rotated_framebuffer_palette_scaler.sv
